/* sv/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, sizing function and controller/datapath link types for
// the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [5:0] ASCII_ZERO  = 6'd48;
   localparam logic [5:0] ASCII_MINUS = 6'd45;

   // number of decimal digits of the largest magnitude, 2**(w-1)
   function automatic int digit_count(input int w);
      logic [64:0] v;
      int          n;
      v = 65'd1 << (w - 1);
      n = 0;
      for (int i = 0; i < 21; i++) begin
         if (v != 65'd0) begin
            v = v / 10;
            n = n + 1;
         end
      end
      return n;
   endfunction

   typedef struct packed {
      logic load;
      logic shift_bit;
      logic shift_digit;
      logic put_sign;
      logic put_digit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic top_zero;
   } sts_type;

endpackage

/* sv/itoa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude register, shift-add-3 BCD register and the result
// beat register.
// ----------------------------------------------------------------------------
module itoa_dp
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic [5:0]             rsp_char_code,
   output logic                   rsp_last_char
);

   localparam int NDIG  = digit_count(VALUE_WIDTH);
   localparam int BCD_W = 4 * NDIG;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic                   neg_ff, neg_in;
   logic [5:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic [3:0]             top_digit;

   assign raw       = req_value;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in = raw[VALUE_WIDTH-1];
         mag_in = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
         bcd_in = '0;
      end else if (cmd.shift_bit) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
      end else if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
      if (cmd.put_sign) begin
         char_in = ASCII_MINUS;
         last_in = 1'b0;
      end else if (cmd.put_digit) begin
         char_in = ASCII_ZERO + {2'b00, top_digit};
         last_in = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign sts.neg        = neg_ff;
   assign sts.top_zero   = (top_digit == 4'd0);
   assign rsp_char_code  = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

/* sv/itoa_ctl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctl
// Controller: sequences conversion, leading zero skip and character emission,
// and owns the result beat valid.
// ----------------------------------------------------------------------------
module itoa_ctl
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int NDIG  = digit_count(VALUE_WIDTH);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_W = $clog2(NDIG + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIG_W-1:0] rem_ff, rem_in;
   logic             started_ff, started_in;
   logic             valid_ff, valid_in;
   logic             slot_free;
   logic             skip;

   assign slot_free = !valid_ff || !rsp_stall;
   assign skip      = !started_ff && sts.top_zero && (rem_ff != DIG_W'(1));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(VALUE_WIDTH);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift_bit = 1'b1;
            cnt_in        = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               rem_in     = DIG_W'(NDIG);
               started_in = 1'b0;
               state_in   = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!sts.neg) begin
               state_in = ST_EMIT;
            end else if (slot_free) begin
               cmd.put_sign = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip) begin
               cmd.shift_digit = 1'b1;
               rem_in          = rem_ff - DIG_W'(1);
            end else if (slot_free) begin
               cmd.put_digit   = 1'b1;
               cmd.shift_digit = 1'b1;
               cmd.last        = (rem_ff == DIG_W'(1));
               started_in      = 1'b1;
               rem_in          = rem_ff - DIG_W'(1);
               if (rem_ff == DIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.put_sign || cmd.put_digit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rem_ff     <= '0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer to its decimal ASCII text, one character per
// result beat, most significant first, with a last-character flag.
//
// Input channel req_: one beat carries req_value; it is taken when req_valid
// is high and req_stall is low. One value is converted at a time.
// Result channel rsp_: rsp_char_code ('-' or '0'..'9') and rsp_last_char,
// taken when rsp_valid is high and rsp_stall is low. The output register
// holds its beat while stalled; the next value may be accepted while the
// final character of the previous one still waits.
// Sequence: after the accept, the shift-add-3 converter shifts in the
// magnitude one bit per cycle, MSB first, then the sign check, then one
// decimal digit position per cycle (leading zeros are dropped one per cycle,
// printed digits one per cycle when the output register is free).
// Reset (synchronous) returns the controller to idle and clears rsp_valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [5:0]                    rsp_char_code,
   output logic                          rsp_last_char
);

   cmd_type cmd;
   sts_type sts;

   itoa_ctl #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   itoa_dp #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* sv/itoa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_checker
   import itoa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_char_code,
   input logic       rsp_last_char
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code)
                                 && $stable(rsp_last_char))
      else $error("stalled result beat changed");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_code == ASCII_MINUS
                    || (rsp_char_code >= ASCII_ZERO
                        && rsp_char_code <= ASCII_ZERO + 6'd9))
      else $error("illegal character code");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == ASCII_MINUS |-> !rsp_last_char)
      else $error("minus sign flagged as last character");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again during conversion");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char)
);

/* test/itoa_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_text_checker
// Watches both channels of the signed integer to decimal text converter.
// Every accepted value is spelled out here as the expected run of characters
// (optional minus sign, then digits, last flag on the final digit), and every
// accepted result beat is compared with the oldest expected character.
// Beats are sampled on the falling edge, where all signals are settled and
// equal to what the next rising edge will take.
// ----------------------------------------------------------------------------
module itoa_text_checker
   import itoa_pkg::*;
#(
   parameter int W = VALUE_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  logic [W-1:0] req_value,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic [5:0]   rsp_char_code,
   input  logic         rsp_last_char,
   output int           fail_count,
   output int           open_chars
);

   typedef struct packed {
      logic [5:0] code;
      logic       last;
   } text_char_type;

   text_char_type expected_text [$];
   text_char_type want;
   int            errors = 0;
   int            queued = 0;

   assign fail_count = errors;
   assign open_chars = queued;

   function automatic void spell_decimal(input logic [W-1:0] raw);
      logic [W-1:0]  mag;
      logic [3:0]    digs [20];
      int            nd;
      text_char_type c;
      mag = raw[W-1] ? (~raw + 1'b1) : raw;
      nd  = 0;
      do begin
         digs[nd] = 4'(mag % 10);
         mag      = mag / 10;
         nd++;
      end while (mag != 0 && nd < 20);
      if (raw[W-1]) begin
         c.code = ASCII_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
         c.code = ASCII_ZERO + 6'(digs[k]);
         c.last = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            spell_decimal(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character beat: code %0d last %0b",
                        $time, rsp_char_code, rsp_last_char);
               errors++;
            end else begin
               want = expected_text.pop_front();
               if (want.code !== rsp_char_code) begin
                  $display("%0t: char_code mismatch: expected %0d, actual %0d",
                           $time, want.code, rsp_char_code);
                  errors++;
               end
               if (want.last !== rsp_last_char) begin
                  $display("%0t: last_char mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last_char);
                  errors++;
               end
            end
         end
      end
      queued = expected_text.size();
   end

endmodule

/* test/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Drives the converter with corner values (zero, one digit, decade edges,
// both extremes including the most negative value) and then a random mix of
// full-range, per-decade, near-extreme and power-of-ten values, in bursts with
// random gaps while the result side stalls on its own pattern. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
   import itoa_pkg::*;

   localparam int W           = VALUE_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 430;
   localparam int CYCLE_LIMIT  = 600000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [W-1:0] req_value = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [5:0]   rsp_char_code;
   logic         rsp_last_char;
   int           fail_count;
   int           open_chars;
   int           burst_left = 0;
   int           stall_left = 0;
   int           free_left  = 0;
   int           cycle_count = 0;

   int corner_values [] = '{0, 1, -1, 5, -5, 9, 10, -10, 42, 99, 100, -123,
                            999999999, 1000000000, -1000000000, 1234567890,
                            2147483646, 2147483647, -2147483647, -2147483647 - 1,
                            32'h55555555, 32'hAAAAAAAA};

   always #5 clock = ~clock;

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(W)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   itoa_text_checker #(.W(W)) u_text_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .open_chars    (open_chars)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 7);
         free_left  = $urandom_range(0, 10) + (($urandom_range(0, 5) == 0) ? 80 : 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d characters outstanding", $time, open_chars);
         $display("** signed_int_to_decimal_ascii: FAILED **");
         $finish;
      end
   end

   function automatic logic [W-1:0] pick_value();
      int          mode;
      int          d;
      longint      p;
      longint      hi;
      logic [W-1:0] v;
      mode = $urandom_range(0, 9);
      d    = $urandom_range(0, 9);
      p    = 1;
      for (int i = 0; i < d; i++) p = p * 10;
      if (mode <= 2) begin
         v = $urandom;
      end else if (mode <= 6) begin
         hi = (d == 9) ? 64'd2147483647 : p * 10 - 1;
         v  = $urandom_range(32'(hi), (d == 0) ? 0 : 32'(p));
         if ($urandom_range(0, 1)) v = -v;
      end else if (mode == 7) begin
         v = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 20)
                                  : 32'h80000000 + $urandom_range(0, 20);
      end else begin
         v = 32'(p) + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   task automatic send_value(input logic [W-1:0] v);
      int  gap;
      logic took;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic drain_text();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (open_chars != 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain_text();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_value(pick_value());
         if (n == RANDOM_ITEMS / 2) drain_text();
      end
      drain_text();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && open_chars == 0) begin
         $display("** signed_int_to_decimal_ascii: PASSED **");
      end else begin
         $display("** signed_int_to_decimal_ascii: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/itoa_pkg.sv
sv/itoa_dp.sv
sv/itoa_ctl.sv
sv/signed_int_to_decimal_ascii.sv
sv/itoa_checker.sv
test/itoa_text_checker.sv
test/tb_signed_int_to_decimal_ascii.sv
